// ===== rtl/brx_pkg.sv =====
// Package with the sequencer states and generator constants of the bounded random block.
package brx_pkg;

  // Word width of the generator and of the bound.
  localparam int unsigned WORD_BITS = 32;

  // SplitMix64 increment and multipliers.
  localparam logic [63:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAW,
    S_CHECK,
    S_MOD,
    S_SEED_ADD,
    S_M0,
    S_M1,
    S_M2,
    S_M3
  } state_t;

endpackage

// ===== rtl/bounded_random_xoshiro128plus.sv =====
// Top level of the bounded random block: xoshiro128+ draws scaled into [0, bound), or zero for a zero bound.
//
//   channel  | valid     | stall     | payload
//   ---------+-----------+-----------+---------------------------------
//   input    | in_valid  | in_stall  | bound [31:0]
//   output   | out_valid | out_stall | value [31:0]
//   seed     | seed_wr_en| (none)    | seed_wr_data [63:0]
//
// A word passes through accept, multiply and check when the first draw is taken.
// A first draw whose low half falls below the bound adds the bit-serial threshold
// remainder and one more check. Every further draw passes again through multiply
// and check on the shared 32x32 multiplier.
// Reset and every seed write start a SplitMix64 expansion that runs its
// 64-bit multiplies as partial products on the same multiplier; input stalls meanwhile.
// A finished value waits in the output register, and a stalled output holds the
// sequencer in its check state until the register frees up.
module bounded_random_xoshiro128plus (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [brx_pkg::WORD_BITS-1:0] bound,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [brx_pkg::WORD_BITS-1:0] value,
  input  logic                         seed_wr_en,
  input  logic [63:0]                  seed_wr_data
);
  import brx_pkg::*;

  localparam logic [4:0] MOD_LAST = 5'd31;

  state_t state, state_next;

  // Generator words and the precomputed next output word.
  logic [31:0] gw0, gw1, gw2, gw3;
  logic [31:0] x_word;

  // Item registers.
  logic [31:0] n;
  logic        thr_ready;
  logic [31:0] rem;
  logic [31:0] dvd;
  logic [4:0]  mod_cnt;

  // Reseed registers.
  logic [63:0] ctr;
  logic [63:0] z;
  logic [31:0] acc_lo, acc_hi;
  logic        sm_mul2;
  logic        sm_second;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // Combinational helpers.
  logic [31:0] lo;
  logic        draw_rej, need_thr, out_free;
  logic [31:0] g_t, g2_x, g3_x, g1_n, g0_n, g2_n, g3_n, x_next;
  logic [63:0] ctr_next, sm_c, sm_r, sm_w;
  logic [31:0] r_hi;
  logic [32:0] mod_t, mod_diff;
  logic        mod_ge;

  assign lo       = prod[31:0];
  assign draw_rej = thr_ready && (lo < rem);
  assign need_thr = !thr_ready && (lo < n);
  assign out_free = !out_valid || !out_stall;

  // One xoshiro128+ step.
  assign g_t    = gw1 << 9;
  assign g2_x   = gw2 ^ gw0;
  assign g3_x   = gw3 ^ gw1;
  assign g1_n   = gw1 ^ g2_x;
  assign g0_n   = gw0 ^ g3_x;
  assign g2_n   = g2_x ^ g_t;
  assign g3_n   = {g3_x[20:0], g3_x[31:21]};
  assign x_next = g0_n + g3_n;

  // SplitMix64 counter step and result assembly from the partial products.
  assign ctr_next = ctr + SM_GAMMA;
  assign sm_c     = sm_mul2 ? SM_MUL2 : SM_MUL1;
  assign r_hi     = acc_hi + prod[31:0];
  assign sm_r     = {r_hi, acc_lo};
  assign sm_w     = sm_r ^ (sm_r >> 31);

  // One restoring step of the threshold remainder.
  assign mod_t    = {rem, dvd[31]};
  assign mod_diff = mod_t - {1'b0, n};
  assign mod_ge   = (mod_t >= {1'b0, n});

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) state_next = S_DRAW;
      end
      S_DRAW:  state_next = S_CHECK;
      S_CHECK: begin
        if (draw_rej)      state_next = S_DRAW;
        else if (need_thr) state_next = S_MOD;
        else if (out_free) state_next = S_IDLE;
      end
      S_MOD: begin
        if (mod_cnt == MOD_LAST) state_next = S_CHECK;
      end
      S_SEED_ADD: state_next = S_M0;
      S_M0:       state_next = S_M1;
      S_M1:       state_next = S_M2;
      S_M2:       state_next = S_M3;
      S_M3: begin
        if (!sm_mul2)        state_next = S_M0;
        else if (!sm_second) state_next = S_SEED_ADD;
        else                 state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (seed_wr_en) state_next = S_SEED_ADD;
  end

  // Outputs of the sequencer: multiplier operands and input stall.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DRAW: begin
        mul_a = x_word;
        mul_b = n;
      end
      S_M0: begin
        mul_a = z[31:0];
        mul_b = sm_c[31:0];
      end
      S_M1: begin
        mul_a = z[31:0];
        mul_b = sm_c[63:32];
      end
      S_M2: begin
        mul_a = z[63:32];
        mul_b = sm_c[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    in_stall = (state != S_IDLE) || seed_wr_en;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SEED_ADD;
      out_valid <= 1'b0;
      thr_ready <= 1'b0;
      sm_mul2   <= 1'b0;
      sm_second <= 1'b0;
      mod_cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CHECK && !draw_rej && !need_thr && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)                         out_valid <= 1'b0;
      if (state == S_IDLE && in_valid && !in_stall) thr_ready <= 1'b0;
      else if (state == S_MOD && mod_cnt == MOD_LAST) thr_ready <= 1'b1;
      if (state == S_CHECK && need_thr) mod_cnt <= '0;
      else if (state == S_MOD)          mod_cnt <= mod_cnt + 5'd1;
      if (seed_wr_en) begin
        sm_mul2   <= 1'b0;
        sm_second <= 1'b0;
      end else if (state == S_M3) begin
        if (!sm_mul2) begin
          sm_mul2 <= 1'b1;
        end else begin
          sm_mul2   <= 1'b0;
          sm_second <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // The product is held while it is checked or waits for the output register.
    if (state == S_DRAW || state == S_M0 || state == S_M1 || state == S_M2) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    if (rst) begin
      ctr <= 64'd1;
    end else if (seed_wr_en) begin
      ctr <= seed_wr_data;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) n <= bound;
        end
        S_DRAW: begin
          gw0    <= g0_n;
          gw1    <= g1_n;
          gw2    <= g2_n;
          gw3    <= g3_n;
          x_word <= x_next;
        end
        S_CHECK: begin
          if (need_thr) begin
            rem <= '0;
            dvd <= 32'd0 - n;
          end else if (!draw_rej && out_free) begin
            value <= prod[63:32];
          end
        end
        S_MOD: begin
          rem <= mod_ge ? mod_diff[31:0] : mod_t[31:0];
          dvd <= dvd << 1;
        end
        S_SEED_ADD: begin
          ctr <= ctr_next;
          z   <= ctr_next ^ (ctr_next >> 30);
        end
        S_M1: begin
          acc_lo <= prod[31:0];
          acc_hi <= prod[63:32];
        end
        S_M2: begin
          acc_hi <= r_hi;
        end
        S_M3: begin
          if (!sm_mul2) begin
            z <= sm_r ^ (sm_r >> 27);
          end else if (!sm_second) begin
            gw0 <= sm_w[31:0];
            gw1 <= sm_w[63:32];
          end else begin
            gw2    <= sm_w[31:0];
            gw3    <= sm_w[63:32];
            x_word <= gw0 + sm_w[63:32];
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  // An accepted word always starts with a draw.
  a_accept_draws: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DRAW))
    else $error("accepted word did not start a draw");

  // The running remainder stays below the bound while the threshold is formed.
  a_rem_below_n: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> (rem < n))
    else $error("threshold remainder reached the bound");

  // A ready threshold is below the bound.
  a_thr_below_n: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && thr_ready) |-> (rem < n))
    else $error("threshold not below bound");

  // A delivered value lies below its bound, or is zero for a zero bound.
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && state_next == S_IDLE && !seed_wr_en) |=>
      (out_valid && ((n == 32'd0 && value == 32'd0) || (n != 32'd0 && value < n))))
    else $error("value out of range");
`endif

endmodule

// ===== tb/sv/tb_bounded_random_xoshiro128plus.sv =====
// Self-checking testbench for the bounded random block, checked against its own generator model.
`timescale 1ns / 1ps

module tb_bounded_random_xoshiro128plus;

  localparam int unsigned RANDOM_PER_PHASE = 157;
  localparam int unsigned PHASES           = 5;
  localparam int unsigned DRAIN_CYCLES     = 60;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  // One row of the directed stimulus; want is used only when known is set.
  typedef struct packed {
    logic [31:0] n;
    logic        known;
    logic [31:0] want;
  } probe_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [brx_pkg::WORD_BITS-1:0] bound = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [brx_pkg::WORD_BITS-1:0] value;
  logic                          seed_wr_en = 1'b0;
  logic [63:0]                   seed_wr_data = '0;

  // Generator state of the model and the values still owed by the block.
  logic [31:0] gen_state [4];
  logic [31:0] pending_values [$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned values_checked = 0;
  int unsigned redraw_count = 0;
  int unsigned zero_bounds = 0;
  int unsigned seeds_written = 0;
  int unsigned cycle_count = 0;

  probe_t probe_rows [0:17] = '{
    '{32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0001, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0002, 1'b0, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{32'h8000_0000, 1'b0, 32'h0000_0000},
    '{32'h8000_0001, 1'b0, 32'h0000_0000},
    '{32'h8000_0001, 1'b0, 32'h0000_0000},
    '{32'h8000_0001, 1'b0, 32'h0000_0000},
    '{32'h0000_0003, 1'b0, 32'h0000_0000},
    '{32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{32'hAAAA_AAAB, 1'b0, 32'h0000_0000},
    '{32'h0001_0000, 1'b0, 32'h0000_0000},
    '{32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
    '{32'hC000_0001, 1'b0, 32'h0000_0000},
    '{32'h0000_0001, 1'b1, 32'h0000_0000},
    '{32'h0000_000A, 1'b0, 32'h0000_0000},
    '{32'h4000_0001, 1'b0, 32'h0000_0000}
  };

  bounded_random_xoshiro128plus dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .bound        (bound),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data)
  );

  // The clock runs with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Expand a 64-bit seed into the four generator words with two SplitMix64 outputs.
  function automatic void reseed_model(input logic [63:0] s);
    logic [63:0] ctr;
    logic [63:0] z;
    ctr = s;
    for (int k = 0; k < 2; k++) begin
      ctr = ctr + brx_pkg::SM_GAMMA;
      z = ctr;
      z = (z ^ (z >> 30)) * brx_pkg::SM_MUL1;
      z = (z ^ (z >> 27)) * brx_pkg::SM_MUL2;
      z = z ^ (z >> 31);
      gen_state[2 * k]     = z[31:0];
      gen_state[2 * k + 1] = z[63:32];
    end
  endfunction

  // Advance xoshiro128+ by one step and return its output word.
  function automatic logic [31:0] step_generator();
    logic [31:0] sum;
    logic [31:0] shifted;
    sum = gen_state[0] + gen_state[3];
    shifted = gen_state[1] << 9;
    gen_state[2] = gen_state[2] ^ gen_state[0];
    gen_state[3] = gen_state[3] ^ gen_state[1];
    gen_state[1] = gen_state[1] ^ gen_state[2];
    gen_state[0] = gen_state[0] ^ gen_state[3];
    gen_state[2] = gen_state[2] ^ shifted;
    gen_state[3] = {gen_state[3][20:0], gen_state[3][31:21]};
    return sum;
  endfunction

  // Scale draws into [0, n); a low half below 2^32 mod n forces another draw.
  function automatic logic [31:0] predict_value(input logic [31:0] n);
    logic [63:0] prod;
    logic [31:0] thr;
    prod = {32'd0, step_generator()} * {32'd0, n};
    if (prod[31:0] < n) begin
      thr = (32'd0 - n) % n;
      while (prod[31:0] < thr) begin
        redraw_count++;
        prod = {32'd0, step_generator()} * {32'd0, n};
      end
    end
    return prod[63:32];
  endfunction

  // Mix of bound shapes: wide random, small, powers of two and bounds that reject often.
  function automatic logic [31:0] pick_bound();
    case ($urandom_range(9))
      0, 1, 2: return $urandom();
      3:       return $urandom_range(16);
      4:       return 32'd1 << $urandom_range(31);
      5:       return 32'h8000_0000 + $urandom_range(255);
      6:       return 32'hFFFF_FFFF - $urandom_range(3);
      7:       return 32'h4000_0000 + $urandom_range(1023);
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  // Offer one bound after a random gap and record its value once the word is taken.
  task automatic send_bound(input logic [31:0] n, input logic known, input logic [31:0] want);
    logic [31:0] predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    bound <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_value(n);
    if (n == 32'd0) zero_bounds++;
    pending_values.push_back(known ? want : predicted);
  endtask

  // Reseed only once the block has delivered everything and sits idle.
  task automatic write_seed(input logic [63:0] s);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_values.size() != 0 || in_stall || out_valid) @(posedge clk);
    seed_wr_en <= 1'b1;
    seed_wr_data <= s;
    @(posedge clk);
    seed_wr_en <= 1'b0;
    reseed_model(s);
    seeds_written++;
  endtask

  // Output side: compare each accepted word with the oldest expected value.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_values.size() == 0) begin
        $error("value: expected no word, actual %h", value);
        mismatch_count++;
      end else begin
        want = pending_values.pop_front();
        values_checked++;
        if (value !== want) begin
          $error("value: expected %h, actual %h", want, value);
          mismatch_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Phases: reset seed with the directed rows, then written seeds including both extremes.
  initial begin
    logic [63:0] next_seed;
    reseed_model(64'd1);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        send_gap_pct   = 37;
        recv_stall_pct = 51;
      end else if (p < 4) begin
        send_gap_pct   = 51;
        recv_stall_pct = 37;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end

      if (p == 0) begin
        foreach (probe_rows[r]) begin
          send_bound(probe_rows[r].n, probe_rows[r].known, probe_rows[r].want);
        end
      end else begin
        case (p)
          1:       next_seed = 64'h0;
          2:       next_seed = 64'hFFFF_FFFF_FFFF_FFFF;
          3:       next_seed = {$urandom(), $urandom()};
          default: next_seed = 64'h1;
        endcase
        write_seed(next_seed);
      end

      repeat (RANDOM_PER_PHASE) send_bound(pick_bound(), 1'b0, 32'd0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d values over %0d seed writes plus the reset seed.",
             values_checked, seeds_written);
    $display("Zero bounds: %0d, redraws after rejection: %0d.", zero_bounds, redraw_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/brx_pkg.sv
rtl/bounded_random_xoshiro128plus.sv
tb/sv/tb_bounded_random_xoshiro128plus.sv
